// ===== design/psu_pkg.sv =====
// ----------------------------------------------------------------------------
// psu_pkg
// Shared types and constants for the particle swarm update block.
// ----------------------------------------------------------------------------
package psu_pkg;

  localparam int unsigned DIMS   = 6;
  localparam int unsigned GAIN_W = 18;
  localparam int unsigned RAND_W = 16;
  localparam int unsigned MUL_BW = 33;
  localparam int unsigned PROD_W = GAIN_W + 1 + MUL_BW;
  localparam int unsigned ACC_W  = 54;

  typedef logic signed [31:0] q16_t;

  localparam logic [1:0] REG_INERTIA   = 2'd0;
  localparam logic [1:0] REG_COGNITIVE = 2'd1;
  localparam logic [1:0] REG_SOCIAL    = 2'd2;

  localparam logic [GAIN_W-1:0] INERTIA_RESET = 18'd52429;
  localparam logic [GAIN_W-1:0] GAIN_RESET    = 18'd6554;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_SCORE_RD,
    ST_SCORE_CMP,
    ST_COPY_RD,
    ST_COPY_WR,
    ST_SCAN_RD,
    ST_SCAN_CMP,
    ST_GCOPY_RD,
    ST_GCOPY_WR,
    ST_ADVANCE,
    ST_K1,
    ST_K2,
    ST_K3,
    ST_MV_RD,
    ST_MV_M0,
    ST_MV_M1,
    ST_MV_M2,
    ST_MV_ACC,
    ST_MV_RND,
    ST_MV_WR,
    ST_REP_RD,
    ST_REP_WR
  } state_e;

endpackage

// ===== design/psu_mac.sv =====
// ----------------------------------------------------------------------------
// psu_mac
// Shared registered multiplier: unsigned gain times signed operand.
// ----------------------------------------------------------------------------
module psu_mac
  import psu_pkg::*;
(
  input  logic                     clk_i,
  input  logic [GAIN_W-1:0]        a_i,
  input  logic signed [MUL_BW-1:0] b_i,
  output logic signed [PROD_W-1:0] prod_o
);

  logic signed [PROD_W-1:0] prod_q;

  always_ff @(posedge clk_i) begin
    prod_q <= $signed({1'b0, a_i}) * b_i;
  end

  assign prod_o = prod_q;

endmodule

// ===== design/particle_swarm_update.sv =====
// ----------------------------------------------------------------------------
// particle_swarm_update
// Global-best particle swarm update over six dimensions in Q16.16.
// ----------------------------------------------------------------------------
// Channel  Dir  Handshake                      Payload
// in       in   in_valid_i / in_ready_o        mode, particle, component, values
// out      out  out_valid_o / out_ready_i      param_0..5, next_particle, flag
// cfg      in   cfg_we_i                       cfg_index_i, cfg_data_i
//
// A load transaction is taken while the block is idle. A fitness transaction
// scores, copies the personal best (when taken), scans the personal bests,
// copies the global best, advances, forms the gain products, moves (six passes
// of the shared multiplier) and reports; the first round skips the scan and
// global copy, and all but its last transaction skip the move.
// Reset clears control state and the global best and loads the gain defaults;
// the particle memories are undefined until loaded. A waiting result holds the
// next fitness transaction at the start of its report until it is taken.
module particle_swarm_update
  import psu_pkg::*;
#(
  parameter int unsigned PARTICLES = 16
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [1:0]        cfg_index_i,
  input  logic [GAIN_W-1:0] cfg_data_i,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic              in_mode_i,
  input  logic [3:0]        in_particle_i,
  input  logic [2:0]        in_component_i,
  input  q16_t              in_pos_value_i,
  input  q16_t              in_vel_value_i,
  input  q16_t              in_fitness_i,
  input  logic [RAND_W-1:0] in_rand1_i,
  input  logic [RAND_W-1:0] in_rand2_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output q16_t              out_param_0_o,
  output q16_t              out_param_1_o,
  output q16_t              out_param_2_o,
  output q16_t              out_param_3_o,
  output q16_t              out_param_4_o,
  output q16_t              out_param_5_o,
  output logic [3:0]        out_next_particle_o,
  output logic              out_past_first_round_o
);

  localparam int unsigned DEPTH = PARTICLES * DIMS;
  localparam int unsigned IW    = $clog2(DEPTH);
  localparam int unsigned PW    = $clog2(PARTICLES);
  localparam logic [PW-1:0] LAST_P = PW'(PARTICLES - 1);
  localparam logic [2:0]    LAST_D = 3'(DIMS - 1);

  state_e state_q, state_d;

  logic [GAIN_W-1:0] w_q, c1_q, c2_q, k1_q, k2_q;
  logic [PW-1:0]     cur_q, scan_q, best_q;
  logic [2:0]        dim_q;
  logic              frd_q, out_valid_q;
  logic [3:0]        out_nxt_q;
  logic              out_past_q;
  q16_t              fit_q, best_fit_q, nv_q;
  logic [RAND_W-1:0] r1_q, r2_q;
  q16_t              gbest_q [DIMS];
  q16_t              par_q [DIMS];
  logic signed [ACC_W-1:0] acc_q;

  q16_t pos_mem [DEPTH];
  q16_t vel_mem [DEPTH];
  q16_t pb_mem [DEPTH];
  q16_t pf_mem [PARTICLES];
  q16_t pos_rd, vel_rd, pb_rd, pf_rd;

  logic in_acc, load_acc, fit_acc, load_ok, pb_better;
  logic [IW-1:0] cur_idx, load_idx, pos_wa, pb_ra;
  logic [PW-1:0] pf_ra;
  logic pos_we, vel_we, pb_we, pf_we;
  q16_t pos_wd, vel_wd;
  logic [GAIN_W-1:0] mul_a;
  logic signed [MUL_BW-1:0] mul_b;
  logic signed [PROD_W-1:0] prod;
  logic [34:0] k_round;
  logic signed [ACC_W-1:0] acc_rnd;
  logic signed [ACC_W-17:0] acc_sh;
  q16_t nv_sat, nx_sat;
  logic signed [32:0] nx_sum;

  assign cur_idx  = IW'(IW'(cur_q) * IW'(DIMS) + IW'(dim_q));
  assign load_idx = IW'(32'(in_particle_i) * DIMS + 32'(in_component_i));
  assign load_ok  = (32'(in_particle_i) < PARTICLES) && (32'(in_component_i) < DIMS);

  assign in_ready_o = (state_q == ST_IDLE);
  assign in_acc     = in_valid_i && in_ready_o;
  assign load_acc   = in_acc && !in_mode_i;
  assign fit_acc    = in_acc && in_mode_i;
  assign pb_better  = !frd_q || (pf_rd < fit_q);

  // Rounding of the velocity sum and saturation of both results.
  assign acc_rnd = acc_q + ACC_W'(32768);
  assign acc_sh  = acc_rnd[ACC_W-1:16];
  assign nv_sat  = (acc_sh[ACC_W-17:31] == {(ACC_W-47){acc_sh[31]}}) ? acc_sh[31:0]
                 : (acc_sh[ACC_W-17] ? 32'sh8000_0000 : 32'sh7fff_ffff);
  assign nx_sum  = {pos_rd[31], pos_rd} + {nv_q[31], nv_q};
  assign nx_sat  = (nx_sum[32] == nx_sum[31]) ? nx_sum[31:0]
                 : (nx_sum[32] ? 32'sh8000_0000 : 32'sh7fff_ffff);
  assign k_round = prod[34:0] + 35'd32768;

  psu_mac u_mac (
    .clk_i  (clk_i),
    .a_i    (mul_a),
    .b_i    (mul_b),
    .prod_o (prod)
  );

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:      if (fit_acc) state_d = ST_SCORE_RD;
      ST_SCORE_RD:  state_d = ST_SCORE_CMP;
      ST_SCORE_CMP: state_d = pb_better ? ST_COPY_RD : ST_SCAN_RD;
      ST_COPY_RD:   state_d = ST_COPY_WR;
      ST_COPY_WR: begin
        if (dim_q != LAST_D) state_d = ST_COPY_RD;
        else state_d = frd_q ? ST_SCAN_RD : ST_ADVANCE;
      end
      ST_SCAN_RD:   state_d = ST_SCAN_CMP;
      ST_SCAN_CMP:  state_d = (scan_q == LAST_P) ? ST_GCOPY_RD : ST_SCAN_RD;
      ST_GCOPY_RD:  state_d = ST_GCOPY_WR;
      ST_GCOPY_WR:  state_d = (dim_q == LAST_D) ? ST_ADVANCE : ST_GCOPY_RD;
      ST_ADVANCE:   state_d = (frd_q || cur_q == LAST_P) ? ST_K1 : ST_REP_RD;
      ST_K1:        state_d = ST_K2;
      ST_K2:        state_d = ST_K3;
      ST_K3:        state_d = ST_MV_RD;
      ST_MV_RD:     state_d = ST_MV_M0;
      ST_MV_M0:     state_d = ST_MV_M1;
      ST_MV_M1:     state_d = ST_MV_M2;
      ST_MV_M2:     state_d = ST_MV_ACC;
      ST_MV_ACC:    state_d = ST_MV_RND;
      ST_MV_RND:    state_d = ST_MV_WR;
      ST_MV_WR:     state_d = (dim_q == LAST_D) ? ST_REP_RD : ST_MV_RD;
      // The report registers stay with the earlier result until it is taken.
      ST_REP_RD:    state_d = (dim_q == 3'd0 && out_valid_q) ? ST_REP_RD : ST_REP_WR;
      ST_REP_WR:    state_d = (dim_q == LAST_D) ? ST_IDLE : ST_REP_RD;
      default:      state_d = ST_IDLE;
    endcase
  end

  // Memory ports and multiplier operands.
  always_comb begin
    pos_we = load_acc && load_ok;
    vel_we = load_acc && load_ok;
    pos_wa = load_idx;
    pos_wd = in_pos_value_i;
    vel_wd = in_vel_value_i;
    pb_we  = 1'b0;
    pf_we  = 1'b0;
    pb_ra  = cur_idx;
    pf_ra  = cur_q;
    mul_a  = w_q;
    mul_b  = {vel_rd[31], vel_rd};
    unique case (state_q)
      ST_SCORE_CMP: pf_we = pb_better;
      ST_COPY_WR:   pb_we = 1'b1;
      ST_SCAN_RD:   pf_ra = scan_q;
      ST_GCOPY_RD:  pb_ra = IW'(IW'(best_q) * IW'(DIMS) + IW'(dim_q));
      ST_K1: begin
        mul_a = c1_q;
        mul_b = MUL_BW'(r1_q);
      end
      ST_K2: begin
        mul_a = c2_q;
        mul_b = MUL_BW'(r2_q);
      end
      ST_MV_M1: begin
        mul_a = k1_q;
        mul_b = {pb_rd[31], pb_rd} - {pos_rd[31], pos_rd};
      end
      ST_MV_M2: begin
        mul_a = k2_q;
        mul_b = {gbest_q[dim_q][31], gbest_q[dim_q]} - {pos_rd[31], pos_rd};
      end
      ST_MV_WR: begin
        pos_we = 1'b1;
        vel_we = 1'b1;
        pos_wa = cur_idx;
        pos_wd = nx_sat;
        vel_wd = nv_q;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (pos_we) pos_mem[pos_wa] <= pos_wd;
    pos_rd <= pos_mem[cur_idx];
  end

  always_ff @(posedge clk_i) begin
    if (vel_we) vel_mem[pos_wa] <= vel_wd;
    vel_rd <= vel_mem[cur_idx];
  end

  always_ff @(posedge clk_i) begin
    if (pb_we) pb_mem[cur_idx] <= pos_rd;
    pb_rd <= pb_mem[pb_ra];
  end

  always_ff @(posedge clk_i) begin
    if (pf_we) pf_mem[cur_q] <= fit_q;
    pf_rd <= pf_mem[pf_ra];
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      w_q         <= INERTIA_RESET;
      c1_q        <= GAIN_RESET;
      c2_q        <= GAIN_RESET;
      cur_q       <= '0;
      frd_q       <= 1'b0;
      dim_q       <= '0;
      scan_q      <= '0;
      out_valid_q <= 1'b0;
      out_nxt_q   <= '0;
      out_past_q  <= 1'b0;
      for (int i = 0; i < DIMS; i++) gbest_q[i] <= '0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        unique case (cfg_index_i)
          REG_INERTIA:   w_q  <= cfg_data_i;
          REG_COGNITIVE: c1_q <= cfg_data_i;
          REG_SOCIAL:    c2_q <= cfg_data_i;
          default: ;
        endcase
      end
      if (out_valid_q && out_ready_i) out_valid_q <= 1'b0;
      unique case (state_q)
        ST_SCORE_CMP: begin
          dim_q  <= '0;
          scan_q <= '0;
        end
        ST_COPY_WR, ST_GCOPY_WR, ST_MV_WR: begin
          dim_q <= (dim_q == LAST_D) ? 3'd0 : dim_q + 3'd1;
        end
        ST_SCAN_CMP: scan_q <= scan_q + PW'(1);
        ST_GCOPY_RD: ;
        ST_ADVANCE: begin
          dim_q <= '0;
          if (cur_q == LAST_P) begin
            cur_q <= '0;
            frd_q <= 1'b1;
          end else begin
            cur_q <= cur_q + PW'(1);
          end
        end
        ST_REP_WR: begin
          dim_q <= (dim_q == LAST_D) ? 3'd0 : dim_q + 3'd1;
          if (dim_q == LAST_D) begin
            out_valid_q <= 1'b1;
            out_nxt_q   <= 4'(cur_q);
            out_past_q  <= frd_q;
          end
        end
        default: ;
      endcase
      if (state_q == ST_GCOPY_WR) gbest_q[dim_q] <= pb_rd;
    end
  end

  // Payload and datapath registers.
  always_ff @(posedge clk_i) begin
    if (fit_acc) begin
      fit_q <= in_fitness_i;
      r1_q  <= in_rand1_i;
      r2_q  <= in_rand2_i;
    end
    case (state_q)
      ST_SCAN_CMP: begin
        // Only a strictly greater fitness displaces an earlier particle.
        if (scan_q == '0 || pf_rd > best_fit_q) begin
          best_fit_q <= pf_rd;
          best_q     <= scan_q;
        end
      end
      ST_K2:     k1_q  <= k_round[33:16];
      ST_K3:     k2_q  <= k_round[33:16];
      ST_MV_M1:  acc_q <= ACC_W'(prod);
      ST_MV_M2:  acc_q <= acc_q + ACC_W'(prod);
      ST_MV_ACC: acc_q <= acc_q + ACC_W'(prod);
      ST_MV_RND: nv_q  <= nv_sat;
      ST_REP_WR: par_q[dim_q] <= pos_rd;
      default: ;
    endcase
  end

  assign out_valid_o            = out_valid_q;
  assign out_param_0_o          = par_q[0];
  assign out_param_1_o          = par_q[1];
  assign out_param_2_o          = par_q[2];
  assign out_param_3_o          = par_q[3];
  assign out_param_4_o          = par_q[4];
  assign out_param_5_o          = par_q[5];
  assign out_next_particle_o    = out_nxt_q;
  assign out_past_first_round_o = out_past_q;

  a_ready_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o |-> state_q == ST_IDLE)
    else $error("input ready outside idle");

  a_report_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_REP_WR |-> !out_valid_q)
    else $error("report written while a result is pending");

  a_move_after_round: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_K1 |-> frd_q)
    else $error("particle moved during the first round");

  a_fitness_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fit_acc |=> state_q == ST_SCORE_RD)
    else $error("fitness transaction did not start scoring");

endmodule

// ===== verif/particle_swarm_update_tb.sv =====
// ----------------------------------------------------------------------------
// particle_swarm_update_tb
// Self-checking testbench for the particle swarm update block. It loads the
// whole swarm, runs directed and random fitness transactions under several
// gain settings with random idling on both channels, and compares every
// reported position against a cycle-free predictor of the swarm.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module particle_swarm_update_tb;
  import psu_pkg::*;

  localparam int unsigned NUM_PART   = 16;
  localparam int unsigned DRAIN_WAIT = 300;
  localparam int unsigned CYCLE_LIMIT = 2000000;
  localparam logic [1:0]  REG_NONE   = 2'd3;

  typedef struct {
    logic              mode;
    logic [3:0]        particle;
    logic [2:0]        component;
    q16_t              pos;
    q16_t              vel;
    q16_t              fit;
    logic [RAND_W-1:0] r1;
    logic [RAND_W-1:0] r2;
  } swarm_txn_t;

  typedef struct {
    q16_t       param [DIMS];
    logic [3:0] nxt;
    logic       past;
  } position_report_t;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              cfg_we_i = 1'b0;
  logic [1:0]        cfg_index_i = '0;
  logic [GAIN_W-1:0] cfg_data_i = '0;
  logic              in_valid_i = 1'b0;
  logic              in_ready_o;
  logic              in_mode_i = 1'b0;
  logic [3:0]        in_particle_i = '0;
  logic [2:0]        in_component_i = '0;
  q16_t              in_pos_value_i = '0;
  q16_t              in_vel_value_i = '0;
  q16_t              in_fitness_i = '0;
  logic [RAND_W-1:0] in_rand1_i = '0;
  logic [RAND_W-1:0] in_rand2_i = '0;
  logic              out_valid_o;
  logic              out_ready_i = 1'b0;
  q16_t              out_param_0_o, out_param_1_o, out_param_2_o;
  q16_t              out_param_3_o, out_param_4_o, out_param_5_o;
  logic [3:0]        out_next_particle_o;
  logic              out_past_first_round_o;

  particle_swarm_update #(.PARTICLES(NUM_PART)) uut (.*);

  always #10 clk_i = ~clk_i;

  // Predictor state of the swarm.
  q16_t              swarm_pos [NUM_PART*DIMS];
  q16_t              swarm_vel [NUM_PART*DIMS];
  q16_t              best_pos  [NUM_PART*DIMS];
  q16_t              best_fit  [NUM_PART];
  q16_t              lead_pos  [DIMS];
  q16_t              lead_fit;
  int unsigned       cur_idx;
  logic              round_done;
  logic [GAIN_W-1:0] gain_w, gain_c1, gain_c2;

  position_report_t  pending_reports [$];
  int unsigned       mismatches = 0;
  int unsigned       cycles = 0;
  bit                sender_idles = 1'b1;
  bit                receiver_idles = 1'b1;
  int unsigned       hold_off = 0;

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  function automatic q16_t sat32(longint v);
    if (v > 64'sd2147483647) return 32'sh7fffffff;
    if (v < -64'sd2147483648) return 32'sh80000000;
    return q16_t'(v);
  endfunction

  task automatic move_particle(int unsigned p, logic [RAND_W-1:0] r1, logic [RAND_W-1:0] r2);
    longint k1, k2, x, s;
    q16_t   nv;
    int     i;
    k1 = (longint'(gain_c1) * longint'(r1) + 32768) >>> 16;
    k2 = (longint'(gain_c2) * longint'(r2) + 32768) >>> 16;
    for (int d = 0; d < DIMS; d++) begin
      i = p * DIMS + d;
      x = swarm_pos[i];
      s = longint'(gain_w) * longint'(swarm_vel[i])
        + k1 * (longint'(best_pos[i]) - x)
        + k2 * (longint'(lead_pos[d]) - x);
      nv = sat32((s + 32768) >>> 16);
      swarm_vel[i] = nv;
      swarm_pos[i] = sat32(x + longint'(nv));
    end
  endtask

  task automatic predict_swarm(swarm_txn_t t);
    int unsigned      lead;
    position_report_t rep;
    if (!t.mode) begin
      if (t.particle < NUM_PART && t.component < DIMS) begin
        swarm_pos[t.particle*DIMS + t.component] = t.pos;
        swarm_vel[t.particle*DIMS + t.component] = t.vel;
      end
      return;
    end
    if (!round_done || best_fit[cur_idx] < t.fit) begin
      best_fit[cur_idx] = t.fit;
      for (int d = 0; d < DIMS; d++) best_pos[cur_idx*DIMS + d] = swarm_pos[cur_idx*DIMS + d];
    end
    if (round_done) begin
      lead = 0;
      for (int i = 1; i < NUM_PART; i++) if (best_fit[i] > best_fit[lead]) lead = i;
      lead_fit = best_fit[lead];
      for (int d = 0; d < DIMS; d++) lead_pos[d] = best_pos[lead*DIMS + d];
    end
    cur_idx++;
    if (cur_idx >= NUM_PART) begin
      cur_idx = 0;
      round_done = 1'b1;
    end
    if (round_done) move_particle(cur_idx, t.r1, t.r2);
    for (int d = 0; d < DIMS; d++) rep.param[d] = swarm_pos[cur_idx*DIMS + d];
    rep.nxt  = cur_idx[3:0];
    rep.past = round_done;
    pending_reports.push_back(rep);
  endtask

  // Result checker: one transaction per rising edge at most.
  always @(posedge clk_i) begin
    position_report_t exp_rep;
    q16_t             got [DIMS];
    bit               bad;
    if (out_valid_o && out_ready_i) begin
      got = '{out_param_0_o, out_param_1_o, out_param_2_o,
              out_param_3_o, out_param_4_o, out_param_5_o};
      if (pending_reports.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result for particle %0d", out_next_particle_o);
      end else begin
        exp_rep = pending_reports.pop_front();
        bad = (exp_rep.nxt != out_next_particle_o) || (exp_rep.past != out_past_first_round_o);
        for (int d = 0; d < DIMS; d++) if (exp_rep.param[d] != got[d]) bad = 1'b1;
        if (bad) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("mismatch: exp particle %0d past %0b, got particle %0d past %0b",
                     exp_rep.nxt, exp_rep.past, out_next_particle_o, out_past_first_round_o);
            for (int d = 0; d < DIMS; d++)
              $display("  dim %0d exp %h got %h", d, exp_rep.param[d], got[d]);
          end
        end
      end
    end
  end

  // Receiver: random stall bursts, an optional long hold-off, none at the end.
  initial begin
    int unsigned burst;
    forever begin
      @(negedge clk_i);
      if (hold_off > 0) begin
        out_ready_i = 1'b0;
        hold_off--;
      end else if (receiver_idles && $urandom_range(0, 7) == 0) begin
        burst = $urandom_range(1, 6);
        out_ready_i = 1'b0;
        repeat (burst - 1) @(negedge clk_i);
      end else begin
        out_ready_i = 1'b1;
      end
    end
  end

  task automatic send_item(swarm_txn_t t);
    @(negedge clk_i);
    if (sender_idles && $urandom_range(0, 5) == 0) begin
      in_valid_i = 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk_i);
    end
    in_valid_i     = 1'b1;
    in_mode_i      = t.mode;
    in_particle_i  = t.particle;
    in_component_i = t.component;
    in_pos_value_i = t.pos;
    in_vel_value_i = t.vel;
    in_fitness_i   = t.fit;
    in_rand1_i     = t.r1;
    in_rand2_i     = t.r2;
    do @(posedge clk_i); while (!in_ready_o);
    predict_swarm(t);
    @(negedge clk_i);
    in_valid_i = 1'b0;
  endtask

  function automatic swarm_txn_t load_txn(int p, int c, q16_t pos, q16_t vel);
    swarm_txn_t t;
    t = '{mode: 1'b0, particle: p[3:0], component: c[2:0], pos: pos, vel: vel,
          fit: $urandom, r1: RAND_W'($urandom), r2: RAND_W'($urandom)};
    return t;
  endfunction

  function automatic swarm_txn_t fitness_txn(q16_t fit, logic [15:0] r1, logic [15:0] r2);
    swarm_txn_t t;
    t = '{mode: 1'b1, particle: 4'($urandom), component: 3'($urandom), pos: $urandom,
          vel: $urandom, fit: fit, r1: r1, r2: r2};
    return t;
  endfunction

  // Positions and velocities mostly in a moderate range so moves stay
  // meaningful; an occasional full-range value drives the saturation paths.
  function automatic q16_t pick_value();
    if ($urandom_range(0, 9) == 0) return $urandom;
    return q16_t'($signed($urandom_range(0, 32'h01ff_ffff)) - 32'sh0100_0000);
  endfunction

  task automatic wait_idle();
    wait (pending_reports.size() == 0);
    repeat (DRAIN_WAIT) @(posedge clk_i);
  endtask

  task automatic write_gain(logic [1:0] idx, logic [GAIN_W-1:0] val);
    @(negedge clk_i);
    cfg_we_i    = 1'b1;
    cfg_index_i = idx;
    cfg_data_i  = val;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
    case (idx)
      REG_INERTIA:   gain_w  = val;
      REG_COGNITIVE: gain_c1 = val;
      REG_SOCIAL:    gain_c2 = val;
      default: ;
    endcase
  endtask

  task automatic set_gains(logic [GAIN_W-1:0] w, logic [GAIN_W-1:0] c1, logic [GAIN_W-1:0] c2);
    wait_idle();
    write_gain(REG_INERTIA, w);
    write_gain(REG_COGNITIVE, c1);
    write_gain(REG_SOCIAL, c2);
  endtask

  task automatic run_random(int unsigned n);
    for (int unsigned k = 0; k < n; k++) begin
      if ($urandom_range(0, 3) == 0)
        send_item(load_txn($urandom_range(0, 15), $urandom_range(0, 7),
                           pick_value(), pick_value()));
      else
        send_item(fitness_txn($urandom, RAND_W'($urandom), RAND_W'($urandom)));
    end
  endtask

  task automatic test_load_swarm();
    for (int p = 0; p < NUM_PART; p++)
      for (int c = 0; c < DIMS; c++)
        send_item(load_txn(p, c, pick_value(), pick_value()));
    // Extreme positions and velocities so that later moves saturate both ways.
    send_item(load_txn(3, 0, 32'sh7fffffff, 32'sh7fffffff));
    send_item(load_txn(5, 5, 32'sh80000000, 32'sh80000000));
    // Components six and seven do not exist and must leave the swarm alone.
    send_item(load_txn(2, 6, 32'sh7fffffff, 32'sh80000000));
    send_item(load_txn(15, 7, 32'sh12345678, 32'sh0));
  endtask

  task automatic test_first_round();
    q16_t fits [NUM_PART];
    fits = '{32'sh80000000, 32'sh7fffffff, 32'sh0, 32'sh7fffffff, 32'sh1, 32'shffffffff,
             32'sh00010000, 32'sh7fffffff, 32'sh80000000, 32'sh0, 32'sh40000000,
             32'shc0000000, 32'sh7ffffffe, 32'sh0, 32'sh7fffffff, 32'sh00000005};
    for (int i = 0; i < NUM_PART; i++) send_item(fitness_txn(fits[i], 16'h0, 16'h0));
    // Second round: random factors at their extremes, then equal fitness ties.
    send_item(fitness_txn(32'sh7fffffff, 16'hffff, 16'hffff));
    send_item(fitness_txn(32'sh80000000, 16'h0, 16'hffff));
    send_item(fitness_txn(32'sh7fffffff, 16'hffff, 16'h0));
    send_item(fitness_txn(32'sh7fffffff, 16'h8000, 16'h8000));
    send_item(fitness_txn(32'sh0, 16'hffff, 16'hffff));
  endtask

  task automatic test_gain_extremes();
    set_gains('0, '0, '0);
    run_random(40);
    set_gains('1, '1, '1);
    run_random(40);
    set_gains(INERTIA_RESET, GAIN_RESET, GAIN_RESET);
    // Index three names no register; the gains must not change.
    write_gain(REG_NONE, '1);
    run_random(30);
  endtask

  task automatic test_backpressure();
    wait_idle();
    hold_off = 1500;
    run_random(40);
  endtask

  task automatic test_drain_pause();
    run_random(20);
    wait (pending_reports.size() == 0);
    run_random(20);
  endtask

  task automatic test_random_mix();
    for (int ph = 0; ph < 6; ph++) begin
      set_gains(GAIN_W'($urandom_range(0, 18'h3ffff)), GAIN_W'($urandom_range(0, 18'h3ffff)),
                GAIN_W'($urandom_range(0, 18'h3ffff)));
      run_random(35);
    end
  endtask

  task automatic test_steady_stream();
    set_gains(INERTIA_RESET, GAIN_W'($urandom), GAIN_W'($urandom));
    sender_idles   = 1'b0;
    receiver_idles = 1'b0;
    run_random(100);
  endtask

  initial begin
    for (int i = 0; i < NUM_PART*DIMS; i++) begin
      swarm_pos[i] = '0;
      swarm_vel[i] = '0;
      best_pos[i]  = '0;
    end
    for (int i = 0; i < NUM_PART; i++) best_fit[i] = '0;
    for (int d = 0; d < DIMS; d++) lead_pos[d] = '0;
    lead_fit   = '0;
    cur_idx    = 0;
    round_done = 1'b0;
    gain_w     = INERTIA_RESET;
    gain_c1    = GAIN_RESET;
    gain_c2    = GAIN_RESET;

    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_load_swarm();
    test_first_round();
    test_gain_extremes();
    test_backpressure();
    test_drain_pause();
    test_random_mix();
    test_steady_stream();

    wait_idle();
    if (mismatches == 0 && pending_reports.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
